>>> rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants of the battery voltage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package bvm_pkg;

  localparam int HISTORY_DEPTH = 8;

  localparam int MV_W   = 14;
  localparam int IVL_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;

  localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = MV_W + FILL_W;
  localparam int ALU_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [CIDX_W-1:0] {
    REG_MONITOR_ENABLE  = 3'd0,
    REG_SAMPLE_INTERVAL = 3'd1,
    REG_EXTERNAL_POWER  = 3'd2,
    REG_CUTOFF          = 3'd3,
    REG_WARNING         = 3'd4,
    REG_CRITICAL        = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MEAN,
    S_FLAGS
  } ctl_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_SUM,
    U_DIV,
    U_DONE
  } mean_state_t;

  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] fill;
  } mean_req_t;

  typedef struct packed {
    logic            done;
    logic [MV_W-1:0] mean;
  } mean_rsp_t;

endpackage

`default_nettype wire

>>> rtl/bvm_mean_unit.sv
// ----------------------------------------------------------------------------
// bvm_mean_unit
// Sums the filled history entries one per cycle, then divides the total by
// the fill count one quotient bit per cycle, both on one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_mean_unit
  import bvm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mean_req_t        req,
  output      mean_rsp_t        rsp,
  output      logic [IDX_W-1:0] rd_idx,
  input  wire logic [MV_W-1:0]  rd_data
);

  mean_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [FILL_W-1:0]  div_r, div_nxt;
  logic [FILL_W-1:0]  k_r, k_nxt;
  logic [FILL_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_sub;
  logic [FILL_W:0]    trial;
  logic               ge;

  assign trial  = {rem_r, acc_r[SUM_W-1]};
  assign rd_idx = k_r[IDX_W-1:0];

  // shared adder / subtractor
  assign alu_res = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
  assign ge      = ~alu_res[ALU_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r  <= acc_nxt;
    div_r  <= div_nxt;
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    div_nxt   = div_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    alu_a     = ALU_W'(acc_r);
    alu_b     = ALU_W'(rd_data);
    alu_sub   = 1'b0;
    unique case (state_r)
      U_IDLE: begin
        if (req.start) begin
          acc_nxt   = '0;
          k_nxt     = '0;
          div_nxt   = req.fill;
          state_nxt = U_SUM;
        end
      end
      U_SUM: begin
        acc_nxt = alu_res[SUM_W-1:0];
        k_nxt   = k_r + 1'b1;
        if (k_nxt == div_r) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        // restoring division: one quotient bit shifts into the accumulator
        alu_a    = ALU_W'(trial);
        alu_b    = ALU_W'(div_r);
        alu_sub  = 1'b1;
        rem_nxt  = ge ? alu_res[FILL_W-1:0] : trial[FILL_W-1:0];
        acc_nxt  = {acc_r[SUM_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = U_DONE;
        end
      end
      U_DONE: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  assign rsp.done = (state_r == U_DONE);
  assign rsp.mean = acc_r[MV_W-1:0];

endmodule

`default_nettype wire

>>> rtl/battery_voltage_monitor_core.sv
// ----------------------------------------------------------------------------
// battery_voltage_monitor_core
// Frame-driven battery monitor with a moving-average voltage level.
// ----------------------------------------------------------------------------
// One input beat per display frame carries a millivolt reading, a read-ok
// flag and a prime flag. Each beat produces exactly one output beat with the
// averaged level, warning/critical flags, the latched shutdown flag and a
// changed flag. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block itself
// does not enforce it. A non-recording beat goes through S_FLAGS to the
// output register; a recording beat first waits in S_MEAN while the shared
// adder sums the stored samples (up to HISTORY_DEPTH) one history entry per
// cycle and then produces one quotient bit per cycle. in_stall is high from
// the cycle after a beat is taken until its result is loaded into the output
// register, so one beat is in flight at a time; the next beat can be taken
// while a loaded result waits there. While out_valid and out_stall are high,
// a finished result waits in the control sequencer and the output register
// holds. Synchronous reset clears control state, configuration, counters and
// flags, not the output data; history entries are written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_monitor_core
  import bvm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [MV_W-1:0]   in_sample_mv,
  input  wire logic              in_sample_ok,
  input  wire logic              in_prime,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [MV_W-1:0]   out_average_mv,
  output      logic              out_warning,
  output      logic              out_critical,
  output      logic              out_low_battery_shutdown,
  output      logic              out_status_changed,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // configuration
  logic              enable_r;
  logic [IVL_W-1:0]  interval_r;
  logic [MV_W-1:0]   external_r, cutoff_r, warning_r, critical_r;

  // monitor state
  logic [MV_W-1:0]   hist_r [HISTORY_DEPTH];
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IVL_W-1:0]  fc_r, fc_nxt;
  logic [MV_W-1:0]   avg_r, avg_nxt;
  logic              shut_r, shut_nxt;
  logic              changed_r, changed_nxt;
  logic              check_r, check_nxt;
  ctl_state_t        state_r, state_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;
  logic              warn_c, crit_c, shut_c;

  // accept decode
  logic              accept;
  logic [IVL_W-1:0]  fc_inc;
  logic              counting, fire, record;
  logic              hist_we;

  mean_req_t         mreq;
  mean_rsp_t         mrsp;
  logic [IDX_W-1:0]  rd_idx;

  bvm_mean_unit u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rsp     (mrsp),
    .rd_idx  (rd_idx),
    .rd_data (hist_r[rd_idx])
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fc_inc   = fc_r + 1'b1;
  assign counting = enable_r && !in_prime && (interval_r != '0);
  assign fire     = counting && (fc_inc >= interval_r);
  assign record   = enable_r && in_sample_ok && (in_prime || fire);
  assign hist_we  = accept && record;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      interval_r <= '0;
      external_r <= '0;
      cutoff_r   <= '0;
      warning_r  <= '0;
      critical_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MONITOR_ENABLE:  enable_r   <= cfg_data[0];
        REG_SAMPLE_INTERVAL: interval_r <= cfg_data[IVL_W-1:0];
        REG_EXTERNAL_POWER:  external_r <= cfg_data[MV_W-1:0];
        REG_CUTOFF:          cutoff_r   <= cfg_data[MV_W-1:0];
        REG_WARNING:         warning_r  <= cfg_data[MV_W-1:0];
        REG_CRITICAL:        critical_r <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_r[wp_r] <= in_sample_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      fc_r        <= '0;
      avg_r       <= '0;
      shut_r      <= 1'b0;
      changed_r   <= 1'b0;
      check_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      fc_r        <= fc_nxt;
      avg_r       <= avg_nxt;
      shut_r      <= shut_nxt;
      changed_r   <= changed_nxt;
      check_r     <= check_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // flags from the level after this beat's update
  assign warn_c = enable_r && (avg_r >= external_r) && (avg_r <= warning_r);
  assign crit_c = enable_r && (avg_r >= external_r) && (avg_r <= critical_r);
  assign shut_c = shut_r || (check_r && (avg_r > external_r) && (avg_r <= cutoff_r));

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    fc_nxt        = fc_r;
    avg_nxt       = avg_r;
    shut_nxt      = shut_r;
    changed_nxt   = changed_r;
    check_nxt     = check_r;
    mreq.start    = 1'b0;
    mreq.fill     = fill_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (counting) begin
            fc_nxt = fire ? '0 : fc_inc;
          end
          changed_nxt = 1'b0;
          check_nxt   = record && !in_prime;
          if (record) begin
            wp_nxt     = (wp_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            fill_nxt   = (fill_r == FILL_W'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;
            mreq.start = 1'b1;
            mreq.fill  = fill_nxt;
            state_nxt  = S_MEAN;
          end else begin
            state_nxt = S_FLAGS;
          end
        end
      end
      S_MEAN: begin
        if (mrsp.done) begin
          avg_nxt     = mrsp.mean;
          changed_nxt = (mrsp.mean != avg_r);
          state_nxt   = S_FLAGS;
        end
      end
      S_FLAGS: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          shut_nxt      = shut_c;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_average_mv           <= avg_r;
      out_warning              <= warn_c;
      out_critical             <= crit_c;
      out_low_battery_shutdown <= shut_c;
      out_status_changed       <= changed_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/bvm_checker.sv
// ----------------------------------------------------------------------------
// bvm_checker
// Port-level checks of the battery voltage monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bvm_checker
  import bvm_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire logic [MV_W-1:0] out_average_mv,
  input wire logic            out_warning,
  input wire logic            out_critical,
  input wire logic            out_low_battery_shutdown,
  input wire logic            out_status_changed
);

  // one beat in flight: a taken beat blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a beat was taken");

  // a fresh result releases the input at the same time
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while input still stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the handshake");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average_mv)
      && $stable(out_warning) && $stable(out_critical)
      && $stable(out_low_battery_shutdown) && $stable(out_status_changed))
    else $error("stalled result beat changed");

endmodule

bind battery_voltage_monitor_core bvm_checker u_bvm_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_valid                 (in_valid),
  .in_stall                 (in_stall),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_average_mv           (out_average_mv),
  .out_warning              (out_warning),
  .out_critical             (out_critical),
  .out_low_battery_shutdown (out_low_battery_shutdown),
  .out_status_changed       (out_status_changed)
);

`default_nettype wire
